// ===== hdl/tsms_pkg.sv =====
// Shared constants and types for the two-sorted-sequence median search.
// No dependencies; the interfaces, the top level and the bench import this package.
`timescale 1ns / 1ps

package tsms_pkg;

   localparam int MAX_LEN = 128;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int DATA_W  = 32;
   localparam int LEN_W   = 8;
   localparam int INDEX_W = 7;
   localparam int LENE_W  = ADDR_W + 1;

   typedef enum logic [1:0] {
      OP_WRITE_FIRST  = 2'd0,
      OP_WRITE_SECOND = 2'd1,
      OP_MEDIAN       = 2'd2,
      OP_NONE         = 2'd3
   } op_type;

endpackage

// ===== hdl/tsms_ifs.sv =====
// Valid/ready channel interfaces: request, response and register write.
// Depends on tsms_pkg for field widths and the operation type.
`timescale 1ns / 1ps

interface tsms_req_if;
   import tsms_pkg::*;
   logic                      valid;
   logic                      ready;
   op_type                    operation;
   logic [INDEX_W-1:0]        index;
   logic signed [DATA_W-1:0]  value;
   modport source (output valid, output operation, output index, output value, input ready);
   modport sink (input valid, input operation, input index, input value, output ready);
endinterface

interface tsms_rsp_if;
   import tsms_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  median;
   modport source (output valid, output median, input ready);
   modport sink (input valid, input median, output ready);
endinterface

interface tsms_csr_if;
   import tsms_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [LEN_W-1:0]          data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/two_sorted_median_search.sv =====
// Top level: two element stores in RAM and the halving median search.
// Depends on tsms_pkg, tsms_ifs and tsms_ram.
// Write beat: stored in the cycle it is accepted; a new beat every cycle while no median search is running.
// Median beat: each halving step reads both RAMs (S_ISSUE), then compares (S_EVAL);
// at most ceil(log2(len)) halving steps before the final compare; hold while the response is full.
// Reset: control and response cleared, seq_length set to 1; stores are not cleared.
`timescale 1ns / 1ps

module two_sorted_median_search (
   input  logic       clock,
   input  logic       reset,
   tsms_req_if.sink   req_if,
   tsms_rsp_if.source rsp_if,
   tsms_csr_if.sink   csr_if
);
   import tsms_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_EVAL  = 4'b0100,
      S_HOLD  = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [LEN_W-1:0]          seq_length_ff, seq_length_in;
   logic [ADDR_W-1:0]         lo1_ff, lo1_in, hi1_ff, hi1_in;
   logic [ADDR_W-1:0]         lo2_ff, lo2_in, hi2_ff, hi2_in;
   logic                      final_ff, final_in;
   logic [DATA_W-1:0]         result_ff, result_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]         rsp_median_ff, rsp_median_in;

   logic [LENE_W-1:0]         len_eff;
   logic [LENE_W-1:0]         sum1, sum2;
   logic [ADDR_W-1:0]         mid1, mid2;
   logic                      last_step;
   logic                      req_beat, in_range;
   logic                      we1, we2;
   logic [ADDR_W-1:0]         addr1, addr2;
   logic [DATA_W-1:0]         rd1, rd2;
   logic                      slot_free;

   assign req_beat  = req_if.valid && req_if.ready;
   assign in_range  = int'(req_if.index) < MAX_LEN;
   assign we1       = req_beat && in_range && (req_if.operation == OP_WRITE_FIRST);
   assign we2       = req_beat && in_range && (req_if.operation == OP_WRITE_SECOND);
   assign sum1      = {1'b0, lo1_ff} + {1'b0, hi1_ff};
   assign sum2      = {1'b0, lo2_ff} + {1'b0, hi2_ff};
   assign mid1      = sum1[LENE_W-1:1];
   assign mid2      = sum2[LENE_W-1:1];
   assign last_step = (lo1_ff == hi1_ff) && (lo2_ff == hi2_ff);
   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   assign addr1 = (state_ff == S_IDLE) ? ADDR_W'(req_if.index) : (last_step ? lo1_ff : mid1);
   assign addr2 = (state_ff == S_IDLE) ? ADDR_W'(req_if.index) : (last_step ? lo2_ff : mid2);

   assign req_if.ready  = (state_ff == S_IDLE);
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.median = rsp_median_ff;

   always_comb begin
      priority if (seq_length_ff == '0) begin
         len_eff = LENE_W'(1);
      end else if (int'(seq_length_ff) > MAX_LEN) begin
         len_eff = LENE_W'(MAX_LEN);
      end else begin
         len_eff = LENE_W'(seq_length_ff);
      end
   end

   tsms_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_first_ram (
      .clock (clock),
      .we    (we1),
      .addr  (addr1),
      .wdata (req_if.value),
      .rdata (rd1)
   );

   tsms_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_second_ram (
      .clock (clock),
      .we    (we2),
      .addr  (addr2),
      .wdata (req_if.value),
      .rdata (rd2)
   );

   always_comb begin
      state_in      = state_ff;
      seq_length_in = seq_length_ff;
      lo1_in        = lo1_ff;
      hi1_in        = hi1_ff;
      lo2_in        = lo2_ff;
      hi2_in        = hi2_ff;
      final_in      = final_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_median_in = rsp_median_ff;

      if (csr_if.valid && csr_if.ready) begin
         seq_length_in = csr_if.data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat && (req_if.operation == OP_MEDIAN)) begin
               lo1_in   = '0;
               lo2_in   = '0;
               hi1_in   = ADDR_W'(len_eff - LENE_W'(1));
               hi2_in   = ADDR_W'(len_eff - LENE_W'(1));
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            final_in = last_step;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            priority if (final_ff) begin
               result_in = ($signed(rd1) < $signed(rd2)) ? rd1 : rd2;
               state_in  = S_HOLD;
            end else if (rd1 == rd2) begin
               result_in = rd1;
               state_in  = S_HOLD;
            end else if ($signed(rd1) < $signed(rd2)) begin
               lo1_in   = mid1 + ADDR_W'(sum1[0]);
               hi2_in   = mid2;
               state_in = S_ISSUE;
            end else begin
               hi1_in   = mid1;
               lo2_in   = mid2 + ADDR_W'(sum2[0]);
               state_in = S_ISSUE;
            end
         end
         S_HOLD: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_median_in = result_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         seq_length_ff <= LEN_W'(1);
         rsp_valid_ff  <= 1'b0;
         final_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         seq_length_ff <= seq_length_in;
         rsp_valid_ff  <= rsp_valid_in;
         final_ff      <= final_in;
      end
   end

   always_ff @(posedge clock) begin
      lo1_ff        <= lo1_in;
      hi1_ff        <= hi1_in;
      lo2_ff        <= lo2_in;
      hi2_ff        <= hi2_in;
      result_ff     <= result_in;
      rsp_median_ff <= rsp_median_in;
   end

`ifndef SYNTHESIS
   a_equal_ranges: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ISSUE || state_ff == S_EVAL) |->
         (ADDR_W'(hi1_ff - lo1_ff) == ADDR_W'(hi2_ff - lo2_ff)))
      else $error("search ranges differ in size");

   a_ordered_ranges: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ISSUE || state_ff == S_EVAL) |-> (lo1_ff <= hi1_ff && lo2_ff <= hi2_ff))
      else $error("search range inverted");

   a_median_starts: assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_if.operation == OP_MEDIAN) |=> (state_ff == S_ISSUE))
      else $error("median beat did not start the search");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD && slot_free) |=>
         (rsp_valid_ff && rsp_median_ff == $past(result_ff) && state_ff == S_IDLE))
      else $error("search result not moved to response register");
`endif

endmodule

// ===== hdl/tsms_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tsms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for two_sorted_median_search: loads sorted pairs,
// asks for lower medians and checks each one against an in-bench search.
// Depends on tsms_pkg, tsms_ifs and the two_sorted_median_search RTL.
`timescale 1ns / 1ps

module tb;
   import tsms_pkg::*;

   localparam int ITEM_TARGET   = 1050;
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT   = 4000;
   localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

   typedef struct packed {
      op_type                   op;
      logic [INDEX_W-1:0]       idx;
      logic signed [DATA_W-1:0] val;
   } req_beat_type;

   logic clock = 1'b0;
   logic reset;

   tsms_req_if req_if();
   tsms_rsp_if rsp_if();
   tsms_csr_if csr_if();

   two_sorted_median_search uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #2 clock = ~clock;

   req_beat_type             req_backlog[$];
   logic signed [DATA_W-1:0] expected_medians[$];
   logic signed [DATA_W-1:0] first_store[MAX_LEN];
   logic signed [DATA_W-1:0] second_store[MAX_LEN];
   logic [LEN_W-1:0]         seq_length_q;
   bit                       first_loaded[MAX_LEN];
   bit                       second_loaded[MAX_LEN];
   logic                     req_taken;
   int                       send_idle_pct;
   int                       recv_idle_pct;
   int                       sent_items;
   int                       fail_count;
   int                       quiet_cycles;

   function automatic int effective_len(input logic [LEN_W-1:0] raw);
      if (raw == 0)
         return 1;
      if (raw > MAX_LEN)
         return MAX_LEN;
      return raw;
   endfunction

   // halving search over both stores, lower median of the merged sequence
   function automatic logic signed [DATA_W-1:0] lower_median(input logic [LEN_W-1:0] raw);
      int                       lo_a, hi_a, lo_b, hi_b, mid_a, mid_b;
      logic signed [DATA_W-1:0] a, b;
      lo_a = 0;
      hi_a = effective_len(raw) - 1;
      lo_b = 0;
      hi_b = hi_a;
      while (lo_a != hi_a || lo_b != hi_b) begin
         mid_a = (lo_a + hi_a) / 2;
         mid_b = (lo_b + hi_b) / 2;
         a = first_store[mid_a];
         b = second_store[mid_b];
         if (a == b)
            return a;
         if (a < b) begin
            lo_a = ((lo_a + hi_a) % 2 == 0) ? mid_a : mid_a + 1;
            hi_b = mid_b;
         end else begin
            hi_a = mid_a;
            lo_b = ((lo_b + hi_b) % 2 == 0) ? mid_b : mid_b + 1;
         end
      end
      a = first_store[lo_a];
      b = second_store[lo_b];
      return (a < b) ? a : b;
   endfunction

   function automatic logic signed [DATA_W-1:0] seed_value(input int style);
      case (style)
         0: return $urandom;
         1: return $urandom_range(8) - 4;
         default: return $urandom_range(1) ? MOST_NEG : -1;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] climb(input logic signed [DATA_W-1:0] v,
                                                      input int style);
      longint t;
      t = v;
      case (style)
         0: t = t + $urandom_range(1 << 24);
         1: t = t + $urandom_range(2);
         default: t = t + (($urandom_range(3) == 0) ? longint'(MOST_POS) : 0);
      endcase
      if (t > longint'(MOST_POS))
         t = MOST_POS;
      return t[DATA_W-1:0];
   endfunction

   task automatic queue_beat(input op_type op, input int idx,
                             input logic signed [DATA_W-1:0] val);
      req_beat_type beat;
      beat.op = op;
      beat.idx = INDEX_W'(idx);
      beat.val = val;
      req_backlog.push_back(beat);
      if (op == OP_WRITE_FIRST)
         first_loaded[beat.idx] = 1'b1;
      if (op == OP_WRITE_SECOND)
         second_loaded[beat.idx] = 1'b1;
      if (op != OP_NONE)
         sent_items++;
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (req_backlog.size() != 0 || req_if.valid || expected_medians.size() != 0);
   endtask

   task automatic write_seq_length(input logic [LEN_W-1:0] raw);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data <= raw;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic load_sorted_pair(input int n);
      logic signed [DATA_W-1:0] va, vb;
      int                       style;
      style = $urandom_range(2);
      va = seed_value(style);
      vb = seed_value(style);
      for (int i = 0; i < n; i++) begin
         queue_beat(OP_WRITE_FIRST, i, va);
         queue_beat(OP_WRITE_SECOND, i, vb);
         va = climb(va, style);
         vb = climb(vb, style);
      end
   endtask

   // driver: hold a beat until taken, then advance or idle; randomize response ready
   always @(negedge clock) begin : driver
      req_beat_type beat;
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (!req_if.valid || req_taken) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               beat = req_backlog.pop_front();
               req_if.valid <= 1'b1;
               req_if.operation <= beat.op;
               req_if.index <= beat.idx;
               req_if.value <= beat.val;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : monitor
      logic signed [DATA_W-1:0] want;
      bit                       moved;
      if (reset) begin
         req_taken <= 1'b0;
         seq_length_q = 1;
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            if (expected_medians.size() == 0) begin
               $error("median: no result expected, actual %0d", rsp_if.median);
               fail_count++;
            end else begin
               want = expected_medians.pop_front();
               if (rsp_if.median !== want) begin
                  $error("median: expected %0d, actual %0d", want, rsp_if.median);
                  fail_count++;
               end
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            moved = 1'b1;
            seq_length_q = csr_if.data;
         end
         if (req_if.valid && req_if.ready) begin
            moved = 1'b1;
            case (req_if.operation)
               OP_WRITE_FIRST:  first_store[req_if.index] = req_if.value;
               OP_WRITE_SECOND: second_store[req_if.index] = req_if.value;
               OP_MEDIAN:       expected_medians.push_back(lower_median(seq_length_q));
               default: ;
            endcase
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      logic [LEN_W-1:0] raw;
      int               n, phase, pick;
      bit               need_fill;
      op_type           store_op;

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.operation = OP_NONE;
      req_if.index = '0;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      send_idle_pct = 38;
      recv_idle_pct = 66;
      sent_items = 0;
      fail_count = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // length one at reset: extremes, ignored opcode, equal elements, top index
      queue_beat(OP_WRITE_FIRST, 0, MOST_NEG);
      queue_beat(OP_WRITE_SECOND, 0, MOST_POS);
      queue_beat(OP_MEDIAN, 0, 0);
      queue_beat(OP_NONE, $urandom, $urandom);
      queue_beat(OP_WRITE_FIRST, 0, 7);
      queue_beat(OP_WRITE_SECOND, 0, 7);
      queue_beat(OP_MEDIAN, 0, 0);
      queue_beat(OP_WRITE_FIRST, MAX_LEN - 1, -1);
      queue_beat(OP_WRITE_SECOND, MAX_LEN - 1, MOST_POS);
      queue_beat(OP_MEDIAN, MAX_LEN - 1, -1);
      // zero length behaves as one
      write_seq_length(0);
      queue_beat(OP_MEDIAN, 0, 0);
      // equal midpoints, a halving step, then a broken order
      write_seq_length(3);
      queue_beat(OP_WRITE_FIRST, 0, -9);
      queue_beat(OP_WRITE_FIRST, 1, 5);
      queue_beat(OP_WRITE_FIRST, 2, 9);
      queue_beat(OP_WRITE_SECOND, 0, -2);
      queue_beat(OP_WRITE_SECOND, 1, 5);
      queue_beat(OP_WRITE_SECOND, 2, MOST_POS);
      queue_beat(OP_MEDIAN, 0, 0);
      queue_beat(OP_WRITE_SECOND, 1, 6);
      queue_beat(OP_MEDIAN, 0, 0);
      queue_beat(OP_WRITE_FIRST, 0, MOST_POS);
      queue_beat(OP_MEDIAN, 0, 0);

      phase = 0;
      while (sent_items < ITEM_TARGET) begin
         case (phase)
            0: raw = 2;
            1: raw = MAX_LEN;
            2: raw = 1;
            3: raw = 255;
            4: raw = 200;
            default: begin
               pick = $urandom_range(99);
               if (pick < 5)
                  raw = 0;
               else if (pick < 15)
                  raw = $urandom_range(25, 48);
               else
                  raw = $urandom_range(1, 24);
            end
         endcase
         phase++;
         write_seq_length(raw);
         if (sent_items < ITEM_TARGET / 3) begin
            send_idle_pct = 38;
            recv_idle_pct = 66;
         end else if (sent_items < 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 66;
            recv_idle_pct = 38;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         n = effective_len(raw);
         need_fill = (n <= 48);
         for (int i = 0; i < n; i++)
            if (!first_loaded[i] || !second_loaded[i])
               need_fill = 1'b1;
         if (need_fill)
            load_sorted_pair(n);
         repeat ($urandom_range(2, 5)) begin
            queue_beat(OP_MEDIAN, $urandom, $urandom);
            repeat ($urandom_range(2)) begin
               store_op = $urandom_range(1) ? OP_WRITE_SECOND : OP_WRITE_FIRST;
               case ($urandom_range(3))
                  0: queue_beat(OP_NONE, $urandom, $urandom);
                  1: if (n < MAX_LEN)
                        queue_beat(store_op, $urandom_range(n, MAX_LEN - 1), $urandom);
                  2: queue_beat(store_op, $urandom_range(n - 1), $urandom);
                  default: ;
               endcase
            end
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
